@@ src/gda_pkg.sv @@
// Shared widths, constants and calendar helper functions for the Gregorian
// date add and day-difference block. No dependencies.
package gda_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int COUNT_W  = 20;
  localparam int DIFF_W   = 23;
  // Day number of any 14-bit year, plus a day count, fits in DN_W bits.
  localparam int DN_W     = 23;
  // Day numbers of years 0..9999 fit in CONV_W bits.
  localparam int CONV_W   = 22;
  localparam int DOY_W    = 9;
  localparam int Q100_W   = 8;
  localparam int LEAPS_W  = 13;
  localparam int NSTAGE   = 8;

  localparam logic [YEAR_W-1:0]  YEAR_MAX        = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  VALID_YEAR_LOW  = YEAR_W'(2020);
  localparam logic [YEAR_W-1:0]  VALID_YEAR_HIGH = YEAR_W'(2100);
  localparam logic [MONTH_W-1:0] MONTH_JAN       = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB       = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC       = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DEC_LAST_DAY    = DAY_W'(31);
  localparam logic [DOY_W-1:0]   DAYS_PER_YEAR   = DOY_W'(365);
  // Last day number of year 9999 (day before 10000-01-01).
  localparam logic [DN_W-1:0]    LAST_DAY_NUM    = DN_W'(3652424);

  localparam logic signed [DIFF_W:0] DIFF_HI = (DIFF_W+1)'((1 << (DIFF_W-1)) - 1);
  localparam logic signed [DIFF_W:0] DIFF_LO = (DIFF_W+1)'(-(1 << (DIFF_W-1)));

  // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 43690.
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 =
    RECIP_W'(((1 << RECIP_SHIFT) + 99) / 100);
  localparam int PROD100_W = YEAR_W + RECIP_W;

  // Year estimate: n * 400 / 146097 as a fixed-point reciprocal.
  localparam int EST_SHIFT = 32;
  localparam int RECIP_YEAR_W = 24;
  localparam logic [RECIP_YEAR_W-1:0] RECIP_YEAR =
    RECIP_YEAR_W'((64'd400 << EST_SHIFT) / 64'd146097);
  localparam int PRODEST_W = CONV_W + RECIP_YEAR_W;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_DIFF = 1'b1
  } op_t;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [DN_W-1:0]    daynum_t;
  typedef logic [Q100_W-1:0]  q100_t;

  function automatic q100_t q100_of(input logic [PROD100_W-1:0] prod);
    return prod[RECIP_SHIFT +: Q100_W];
  endfunction

  // Leap test, given q = floor(y/100).
  function automatic logic is_leap(input year_t y, input q100_t q);
    year_t hund;
    hund = YEAR_W'(q) * YEAR_W'(100);
    return (y == hund) ? (q[1:0] == 2'b00) : (y[1:0] == 2'b00);
  endfunction

  // Leap days in years 0..y-1, given q = floor((y-1)/100).
  function automatic logic [LEAPS_W-1:0] leaps_before(input year_t y, input q100_t q);
    year_t p;
    p = y - YEAR_W'(1);
    return (y == '0) ? '0 :
      LEAPS_W'(p >> 2) - LEAPS_W'(q) + LEAPS_W'(q >> 2) + LEAPS_W'(1);
  endfunction

  function automatic daynum_t year_start(input year_t y, input q100_t q);
    return DN_W'(y) * DN_W'(365) + DN_W'(leaps_before(y, q));
  endfunction

  // Days before the first of month m in a common year.
  function automatic logic [DOY_W-1:0] month_start(input month_t m);
    logic [DOY_W-1:0] s;
    unique case (m)
      4'd1:    s = DOY_W'(0);
      4'd2:    s = DOY_W'(31);
      4'd3:    s = DOY_W'(59);
      4'd4:    s = DOY_W'(90);
      4'd5:    s = DOY_W'(120);
      4'd6:    s = DOY_W'(151);
      4'd7:    s = DOY_W'(181);
      4'd8:    s = DOY_W'(212);
      4'd9:    s = DOY_W'(243);
      4'd10:   s = DOY_W'(273);
      4'd11:   s = DOY_W'(304);
      4'd12:   s = DOY_W'(334);
      default: s = DOY_W'(0);
    endcase
    return s;
  endfunction

  // Length of month m; zero for a month outside 1..12.
  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = DAY_W'(0);
    endcase
    return len;
  endfunction

endpackage

@@ src/gda_if.sv @@
// Valid/ready channel interfaces for the Gregorian date block: one for
// input items and one for result items. Depends on gda_pkg.
interface gda_in_if;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  gda_pkg::year_t        year_a;
  gda_pkg::month_t       month_a;
  gda_pkg::day_t         day_a;
  gda_pkg::year_t        year_b;
  gda_pkg::month_t       month_b;
  gda_pkg::day_t         day_b;
  logic [gda_pkg::COUNT_W-1:0] day_count;

  modport source (output valid, operation, year_a, month_a, day_a,
                  year_b, month_b, day_b, day_count, input ready);
  modport sink   (input valid, operation, year_a, month_a, day_a,
                  year_b, month_b, day_b, day_count, output ready);
endinterface

interface gda_out_if;
  logic                  valid;
  logic                  ready;
  gda_pkg::year_t        result_year;
  gda_pkg::month_t       result_month;
  gda_pkg::day_t         result_day;
  logic signed [gda_pkg::DIFF_W-1:0] day_difference;
  logic                  a_valid;
  logic                  year_overflow;

  modport source (output valid, result_year, result_month, result_day,
                  day_difference, a_valid, year_overflow, input ready);
  modport sink   (input valid, result_year, result_month, result_day,
                  day_difference, a_valid, year_overflow, output ready);
endinterface

@@ src/gda_daynum.sv @@
// Two-stage conversion of a calendar date to a day number counted from
// year 0, January 1. Depends on gda_pkg.
module gda_daynum (
  input  logic             clk,
  input  logic [1:0]       load,
  input  gda_pkg::year_t   year,
  input  gda_pkg::month_t  month,
  input  gda_pkg::day_t    day,
  output gda_pkg::daynum_t day_num
);

  gda_pkg::month_t  m_c;
  gda_pkg::day_t    d_c;
  gda_pkg::year_t   p_c;
  logic [gda_pkg::PROD100_W-1:0] prod_p;
  logic [gda_pkg::PROD100_W-1:0] prod_y;

  gda_pkg::year_t   y_r;
  gda_pkg::month_t  m_r;
  gda_pkg::day_t    d_r;
  gda_pkg::q100_t   qp_r;
  gda_pkg::q100_t   qy_r;
  gda_pkg::daynum_t num_nxt;
  gda_pkg::daynum_t num_r;
  logic             leap;

  // Out-of-range months and day zero are clamped to the nearest real value.
  always_comb begin
    if (month < gda_pkg::MONTH_JAN) begin
      m_c = gda_pkg::MONTH_JAN;
    end else if (month > gda_pkg::MONTH_DEC) begin
      m_c = gda_pkg::MONTH_DEC;
    end else begin
      m_c = month;
    end
    d_c    = (day == '0) ? gda_pkg::DAY_W'(1) : day;
    p_c    = (year == '0) ? '0 : year - gda_pkg::YEAR_W'(1);
    prod_p = gda_pkg::PROD100_W'(p_c) * gda_pkg::PROD100_W'(gda_pkg::RECIP_100);
    prod_y = gda_pkg::PROD100_W'(year) * gda_pkg::PROD100_W'(gda_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      y_r  <= year;
      m_r  <= m_c;
      d_r  <= d_c;
      qp_r <= gda_pkg::q100_of(prod_p);
      qy_r <= gda_pkg::q100_of(prod_y);
    end
  end

  always_comb begin
    leap    = gda_pkg::is_leap(y_r, qy_r);
    num_nxt = gda_pkg::year_start(y_r, qp_r)
            + gda_pkg::DN_W'(gda_pkg::month_start(m_r))
            + gda_pkg::DN_W'(d_r - gda_pkg::DAY_W'(1))
            + gda_pkg::DN_W'((m_r > gda_pkg::MONTH_FEB) && leap);
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      num_r <= num_nxt;
    end
  end

  assign day_num = num_r;

endmodule

@@ src/gda_from_days.sv @@
// Five-stage conversion of a day number (years 0..9999) back to year,
// month and day. Depends on gda_pkg.
module gda_from_days (
  input  logic                         clk,
  input  logic [4:0]                   load,
  input  logic [gda_pkg::CONV_W-1:0]   n_in,
  output gda_pkg::year_t               year,
  output gda_pkg::month_t              month,
  output gda_pkg::day_t                day
);

  // Stage 0: year estimate from a reciprocal multiply.
  logic [gda_pkg::PRODEST_W-1:0] prod_est;
  logic [gda_pkg::CONV_W-1:0]    n0_r;
  gda_pkg::year_t                est0_r;

  // Stage 1: hundreds of the three candidate years.
  gda_pkg::year_t                em1_a;
  gda_pkg::year_t                ep1_a;
  logic [gda_pkg::PROD100_W-1:0] prod_m1;
  logic [gda_pkg::PROD100_W-1:0] prod_0;
  logic [gda_pkg::PROD100_W-1:0] prod_p1;
  logic [gda_pkg::CONV_W-1:0]    n1_r;
  gda_pkg::year_t                est1_r;
  gda_pkg::q100_t                qm1_r;
  gda_pkg::q100_t                q0_r;
  gda_pkg::q100_t                qp1_r;

  // Stage 2: year starts and leap flags.
  gda_pkg::year_t                em1_b;
  gda_pkg::year_t                ep1_b;
  logic [gda_pkg::CONV_W-1:0]    n2_r;
  gda_pkg::year_t                est2_r;
  gda_pkg::daynum_t              ys0_r;
  gda_pkg::daynum_t              ys1_r;
  logic                          lm1_r;
  logic                          l0_r;
  logic                          lp1_r;

  // Stage 3: final year and day of year.
  gda_pkg::daynum_t              n_ext;
  gda_pkg::year_t                y_nxt;
  logic [gda_pkg::DOY_W-1:0]     r_nxt;
  logic                          lp_nxt;
  gda_pkg::year_t                y3_r;
  logic [gda_pkg::DOY_W-1:0]     r3_r;
  logic                          lp3_r;

  // Stage 4: month and day.
  gda_pkg::month_t               mo_nxt;
  logic [gda_pkg::DOY_W-1:0]     start_sel;
  logic [gda_pkg::DOY_W-1:0]     start_m;
  gda_pkg::year_t                year_r;
  gda_pkg::month_t               month_r;
  gda_pkg::day_t                 day_r;

  assign prod_est = gda_pkg::PRODEST_W'(n_in) * gda_pkg::PRODEST_W'(gda_pkg::RECIP_YEAR);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      n0_r   <= n_in;
      est0_r <= prod_est[gda_pkg::EST_SHIFT +: gda_pkg::YEAR_W];
    end
  end

  always_comb begin
    em1_a   = (est0_r == '0) ? '0 : est0_r - gda_pkg::YEAR_W'(1);
    ep1_a   = est0_r + gda_pkg::YEAR_W'(1);
    prod_m1 = gda_pkg::PROD100_W'(em1_a) * gda_pkg::PROD100_W'(gda_pkg::RECIP_100);
    prod_0  = gda_pkg::PROD100_W'(est0_r) * gda_pkg::PROD100_W'(gda_pkg::RECIP_100);
    prod_p1 = gda_pkg::PROD100_W'(ep1_a) * gda_pkg::PROD100_W'(gda_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      n1_r   <= n0_r;
      est1_r <= est0_r;
      qm1_r  <= gda_pkg::q100_of(prod_m1);
      q0_r   <= gda_pkg::q100_of(prod_0);
      qp1_r  <= gda_pkg::q100_of(prod_p1);
    end
  end

  always_comb begin
    em1_b = (est1_r == '0) ? '0 : est1_r - gda_pkg::YEAR_W'(1);
    ep1_b = est1_r + gda_pkg::YEAR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      n2_r   <= n1_r;
      est2_r <= est1_r;
      ys0_r  <= gda_pkg::year_start(est1_r, qm1_r);
      ys1_r  <= gda_pkg::year_start(ep1_b, q0_r);
      lm1_r  <= gda_pkg::is_leap(em1_b, qm1_r);
      l0_r   <= gda_pkg::is_leap(est1_r, q0_r);
      lp1_r  <= gda_pkg::is_leap(ep1_b, qp1_r);
    end
  end

  // The estimate is within one year of the true one.
  always_comb begin
    n_ext = gda_pkg::DN_W'(n2_r);
    if (n_ext < ys0_r) begin
      y_nxt  = est2_r - gda_pkg::YEAR_W'(1);
      r_nxt  = gda_pkg::DOY_W'(n_ext + gda_pkg::DN_W'(gda_pkg::DAYS_PER_YEAR)
                               + gda_pkg::DN_W'(lm1_r) - ys0_r);
      lp_nxt = lm1_r;
    end else if (n_ext >= ys1_r) begin
      y_nxt  = est2_r + gda_pkg::YEAR_W'(1);
      r_nxt  = gda_pkg::DOY_W'(n_ext - ys1_r);
      lp_nxt = lp1_r;
    end else begin
      y_nxt  = est2_r;
      r_nxt  = gda_pkg::DOY_W'(n_ext - ys0_r);
      lp_nxt = l0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      y3_r  <= y_nxt;
      r3_r  <= r_nxt;
      lp3_r <= lp_nxt;
    end
  end

  // Month starts rise with the month, so the last match is the month.
  always_comb begin
    mo_nxt    = gda_pkg::MONTH_JAN;
    start_sel = '0;
    for (int i = 2; i <= 12; i++) begin
      start_m = gda_pkg::month_start(gda_pkg::MONTH_W'(i))
              + gda_pkg::DOY_W'((i > 2) && lp3_r);
      if (r3_r >= start_m) begin
        mo_nxt    = gda_pkg::MONTH_W'(i);
        start_sel = start_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      year_r  <= y3_r;
      month_r <= mo_nxt;
      day_r   <= gda_pkg::DAY_W'(r3_r - start_sel) + gda_pkg::DAY_W'(1);
    end
  end

  assign year  = year_r;
  assign month = month_r;
  assign day   = day_r;

endmodule

@@ src/gregorian_date_add_and_diff.sv @@
// Gregorian date adder and day-difference unit, eight register stages.
// Throughput: one item per cycle while out_chan.ready is high; a full
// stage holds while the stage after it does not load.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
// Depends on gda_pkg, gda_if, gda_daynum and gda_from_days.
module gregorian_date_add_and_diff (
  input  logic      clk,
  input  logic      rst_n,
  gda_in_if.sink    in_chan,
  gda_out_if.source out_chan
);

  localparam int LAST = gda_pkg::NSTAGE - 1;

  // Stage map:
  //   0..1  date A and date B to day numbers (two converters in parallel)
  //   2     sum, overflow check, saturated difference
  //   3..7  day number of the sum back to year, month and day
  // A stage loads when empty or when the next stage loads, so bubbles are
  // squeezed out; a stalled output holds full stages back to an empty one.
  logic [gda_pkg::NSTAGE-1:0] v_r;
  logic [gda_pkg::NSTAGE-1:0] load;

  gda_pkg::op_t               op_r [gda_pkg::NSTAGE];
  logic                       av_r [gda_pkg::NSTAGE];
  logic [gda_pkg::COUNT_W-1:0] cnt0_r;
  logic [gda_pkg::COUNT_W-1:0] cnt1_r;
  logic                       ovf_r  [2:LAST];
  logic signed [gda_pkg::DIFF_W-1:0] diff_r [2:LAST];
  logic [gda_pkg::CONV_W-1:0] conv_r;

  logic                       leap_in;
  logic                       av_nxt;
  gda_pkg::daynum_t           na;
  gda_pkg::daynum_t           nb;
  gda_pkg::daynum_t           sum;
  logic                       ovf_nxt;
  logic signed [gda_pkg::DIFF_W:0]   diff_wide;
  logic signed [gda_pkg::DIFF_W-1:0] diff_nxt;
  logic [gda_pkg::CONV_W-1:0] conv_nxt;

  gda_pkg::year_t             fd_year;
  gda_pkg::month_t            fd_month;
  gda_pkg::day_t              fd_day;

  always_comb begin
    load[LAST] = !v_r[LAST] || out_chan.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      load[k] = !v_r[k] || load[k+1];
    end
  end

  assign in_chan.ready = load[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) begin
        v_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < gda_pkg::NSTAGE; k++) begin
        if (load[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // The validity check only matters inside 2020..2100, where the leap rule
  // reduces to a multiple of four other than 2100.
  always_comb begin
    leap_in = (in_chan.year_a[1:0] == 2'b00) && (in_chan.year_a != gda_pkg::VALID_YEAR_HIGH);
    av_nxt  = (in_chan.year_a >= gda_pkg::VALID_YEAR_LOW)
           && (in_chan.year_a <= gda_pkg::VALID_YEAR_HIGH)
           && (in_chan.month_a >= gda_pkg::MONTH_JAN)
           && (in_chan.month_a <= gda_pkg::MONTH_DEC)
           && (in_chan.day_a != '0)
           && (in_chan.day_a <= gda_pkg::month_len(in_chan.month_a, leap_in));
  end

  gda_daynum u_daynum_a (
    .clk     (clk),
    .load    (load[1:0]),
    .year    (in_chan.year_a),
    .month   (in_chan.month_a),
    .day     (in_chan.day_a),
    .day_num (na)
  );

  gda_daynum u_daynum_b (
    .clk     (clk),
    .load    (load[1:0]),
    .year    (in_chan.year_b),
    .month   (in_chan.month_b),
    .day     (in_chan.day_b),
    .day_num (nb)
  );

  // Stage 2: a sum past the end of year 9999 saturates, and the converter
  // then gets day zero so that its year estimate stays in range. The
  // difference only leaves the 23-bit range for years above 9999.
  always_comb begin
    sum       = na + gda_pkg::DN_W'(cnt1_r);
    ovf_nxt   = (op_r[1] == gda_pkg::OP_ADD) && (sum > gda_pkg::LAST_DAY_NUM);
    diff_wide = $signed({1'b0, na}) - $signed({1'b0, nb});
    if (op_r[1] != gda_pkg::OP_DIFF) begin
      diff_nxt = '0;
    end else if (diff_wide > gda_pkg::DIFF_HI) begin
      diff_nxt = gda_pkg::DIFF_HI[gda_pkg::DIFF_W-1:0];
    end else if (diff_wide < gda_pkg::DIFF_LO) begin
      diff_nxt = gda_pkg::DIFF_LO[gda_pkg::DIFF_W-1:0];
    end else begin
      diff_nxt = diff_wide[gda_pkg::DIFF_W-1:0];
    end
    conv_nxt = ((op_r[1] == gda_pkg::OP_ADD) && !ovf_nxt) ? sum[gda_pkg::CONV_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      op_r[0] <= gda_pkg::op_t'(in_chan.operation);
      av_r[0] <= av_nxt;
      cnt0_r  <= in_chan.day_count;
    end
    if (load[1]) begin
      op_r[1] <= op_r[0];
      av_r[1] <= av_r[0];
      cnt1_r  <= cnt0_r;
    end
    if (load[2]) begin
      op_r[2]   <= op_r[1];
      av_r[2]   <= av_r[1];
      ovf_r[2]  <= ovf_nxt;
      diff_r[2] <= diff_nxt;
      conv_r    <= conv_nxt;
    end
    for (int k = 3; k < gda_pkg::NSTAGE; k++) begin
      if (load[k]) begin
        op_r[k]   <= op_r[k-1];
        av_r[k]   <= av_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        diff_r[k] <= diff_r[k-1];
      end
    end
  end

  gda_from_days u_from_days (
    .clk   (clk),
    .load  (load[LAST:3]),
    .n_in  (conv_r),
    .year  (fd_year),
    .month (fd_month),
    .day   (fd_day)
  );

  // The date fields read zero for a difference item and 9999-12-31 when
  // the sum overflowed.
  always_comb begin
    out_chan.valid          = v_r[LAST];
    out_chan.day_difference = diff_r[LAST];
    out_chan.a_valid        = av_r[LAST];
    out_chan.year_overflow  = ovf_r[LAST];
    if (op_r[LAST] == gda_pkg::OP_DIFF) begin
      out_chan.result_year  = '0;
      out_chan.result_month = '0;
      out_chan.result_day   = '0;
    end else if (ovf_r[LAST]) begin
      out_chan.result_year  = gda_pkg::YEAR_MAX;
      out_chan.result_month = gda_pkg::MONTH_DEC;
      out_chan.result_day   = gda_pkg::DEC_LAST_DAY;
    end else begin
      out_chan.result_year  = fd_year;
      out_chan.result_month = fd_month;
      out_chan.result_day   = fd_day;
    end
  end

  // Input is refused only when every stage holds an item.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (&v_r))
    else $error("input refused while a stage is empty");

  a_diff_zero_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (op_r[LAST] == gda_pkg::OP_ADD)) |-> (out_chan.day_difference == '0))
    else $error("difference not zero for an add item");

  a_date_zero_on_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (op_r[LAST] == gda_pkg::OP_DIFF)) |->
      ((out_chan.result_year == '0) && (out_chan.result_month == '0) &&
       (out_chan.result_day == '0) && !out_chan.year_overflow))
    else $error("date fields not zero for a difference item");

  a_add_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (op_r[LAST] == gda_pkg::OP_ADD)) |->
      ((out_chan.result_month >= gda_pkg::MONTH_JAN) &&
       (out_chan.result_month <= gda_pkg::MONTH_DEC) &&
       (out_chan.result_day != '0) &&
       (out_chan.result_year <= gda_pkg::YEAR_MAX)))
    else $error("sum date out of range");

endmodule
